[sv/rsch_pkg.sv]
// ----------------------------------------------------------------------------
// rsch_pkg
// Shared types and constants of the ray segment closest hit block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsch_pkg;

    // Quotient bits kept by the offset divider; larger quotients saturate.
    localparam int DIV_QBITS = 41;
    localparam int DIV_CNTW = 6;
    localparam logic [DIV_QBITS-1:0] Q_CLAMP = 41'h100_0000_0000;

    // The snap slope is unsigned Q8.8.
    localparam int SLOPE_FRAC = 8;

    typedef enum logic [2:0] {
        CFG_RAY_START_X    = 3'd0,
        CFG_RAY_START_Y    = 3'd1,
        CFG_RAY_END_X      = 3'd2,
        CFG_RAY_END_Y      = 3'd3,
        CFG_RAY_MAX_LENGTH = 3'd4,
        CFG_TOLERANCE      = 3'd5,
        CFG_SNAP_SLOPE     = 3'd6,
        CFG_SNAP_ENABLE    = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        C_NOP,
        C_LOAD,
        C_DEN_A,
        C_DEN_B,
        C_DEN_C,
        C_NUM_B,
        C_NUM_C,
        C_OFS_MUL_X,
        C_OFS_MUL_Y,
        C_MUL_RUN,
        C_DIV_START,
        C_DIV_RUN,
        C_OFS_SET_X,
        C_OFS_SET_Y,
        C_CLAMP,
        C_DIFF_R,
        C_DIFF_E,
        C_DIFF_S,
        C_SQ_A,
        C_SQ_B,
        C_SQ_C,
        C_SNAP_E,
        C_SNAP_S,
        C_ROOT_START,
        C_ROOT_RUN,
        C_THR,
        C_THR2_START,
        C_FIN_HIT,
        C_FIN_MISS
    } cmd_t;

    typedef struct packed {
        logic parallel;
        logic box_ok;
        logic mul_done;
        logic div_done;
        logic root_done;
        logic snap_lt;
        logic len_ok;
        logic out_busy;
        logic snap_en;
    } status_t;

endpackage

`default_nettype wire

[sv/rsch_ctrl.sv]
// ----------------------------------------------------------------------------
// rsch_ctrl
// Sequencer that walks the datapath through one segment test.
// ----------------------------------------------------------------------------
`default_nettype none

module rsch_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  rsch_pkg::status_t     st,
    output rsch_pkg::cmd_t        op
);

    typedef enum logic [5:0] {
        S_IDLE, S_DEN_A, S_DEN_B, S_DEN_C, S_NUM_B, S_NUM_C, S_PAR,
        S_MUL_X, S_MRUN_X, S_DIV_X, S_DRUN_X, S_SET_X,
        S_MUL_Y, S_MRUN_Y, S_DIV_Y, S_DRUN_Y, S_SET_Y,
        S_BOX, S_CLAMP, S_DIFF, S_SQ_A, S_SQ_B, S_SQ_C, S_CMP, S_SNAP,
        S_ROOT, S_RRUN, S_THR, S_T2, S_T2RUN, S_LEN, S_FIN_HIT, S_FIN_MISS
    } state_t;

    // Which squared distance the shared square/root path is working on.
    typedef enum logic [1:0] {
        P_D0, P_E, P_S, P_DIST
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        op = rsch_pkg::C_NOP;
        case (state_reg)
            S_IDLE:
            begin
                op = rsch_pkg::C_LOAD;
                if (in_valid)
                begin
                    state_next = S_DEN_A;
                end
            end
            S_DEN_A:
            begin
                op = rsch_pkg::C_DEN_A;
                state_next = S_DEN_B;
            end
            S_DEN_B:
            begin
                op = rsch_pkg::C_DEN_B;
                state_next = S_DEN_C;
            end
            S_DEN_C:
            begin
                op = rsch_pkg::C_DEN_C;
                state_next = S_NUM_B;
            end
            S_NUM_B:
            begin
                op = rsch_pkg::C_NUM_B;
                state_next = S_NUM_C;
            end
            S_NUM_C:
            begin
                op = rsch_pkg::C_NUM_C;
                state_next = S_PAR;
            end
            S_PAR:
            begin
                state_next = st.parallel ? S_FIN_MISS : S_MUL_X;
            end
            S_MUL_X:
            begin
                op = rsch_pkg::C_OFS_MUL_X;
                state_next = S_MRUN_X;
            end
            S_MRUN_X:
            begin
                op = rsch_pkg::C_MUL_RUN;
                if (st.mul_done)
                begin
                    state_next = S_DIV_X;
                end
            end
            S_DIV_X:
            begin
                op = rsch_pkg::C_DIV_START;
                state_next = S_DRUN_X;
            end
            S_DRUN_X:
            begin
                op = rsch_pkg::C_DIV_RUN;
                if (st.div_done)
                begin
                    state_next = S_SET_X;
                end
            end
            S_SET_X:
            begin
                op = rsch_pkg::C_OFS_SET_X;
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                op = rsch_pkg::C_OFS_MUL_Y;
                state_next = S_MRUN_Y;
            end
            S_MRUN_Y:
            begin
                op = rsch_pkg::C_MUL_RUN;
                if (st.mul_done)
                begin
                    state_next = S_DIV_Y;
                end
            end
            S_DIV_Y:
            begin
                op = rsch_pkg::C_DIV_START;
                state_next = S_DRUN_Y;
            end
            S_DRUN_Y:
            begin
                op = rsch_pkg::C_DIV_RUN;
                if (st.div_done)
                begin
                    state_next = S_SET_Y;
                end
            end
            S_SET_Y:
            begin
                op = rsch_pkg::C_OFS_SET_Y;
                state_next = S_BOX;
            end
            S_BOX:
            begin
                state_next = st.box_ok ? S_CLAMP : S_FIN_MISS;
            end
            S_CLAMP:
            begin
                op = rsch_pkg::C_CLAMP;
                phase_next = st.snap_en ? P_D0 : P_DIST;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                if (phase_reg == P_E)
                begin
                    op = rsch_pkg::C_DIFF_E;
                end
                else if (phase_reg == P_S)
                begin
                    op = rsch_pkg::C_DIFF_S;
                end
                else
                begin
                    op = rsch_pkg::C_DIFF_R;
                end
                state_next = S_SQ_A;
            end
            S_SQ_A:
            begin
                op = rsch_pkg::C_SQ_A;
                state_next = S_SQ_B;
            end
            S_SQ_B:
            begin
                op = rsch_pkg::C_SQ_B;
                state_next = S_SQ_C;
            end
            S_SQ_C:
            begin
                op = rsch_pkg::C_SQ_C;
                if (phase_reg == P_E || phase_reg == P_S)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_ROOT;
                end
            end
            S_CMP:
            begin
                if (st.snap_lt)
                begin
                    state_next = S_SNAP;
                end
                else if (phase_reg == P_E)
                begin
                    phase_next = P_S;
                    state_next = S_DIFF;
                end
                else
                begin
                    phase_next = P_DIST;
                    state_next = S_DIFF;
                end
            end
            S_SNAP:
            begin
                op = (phase_reg == P_E) ? rsch_pkg::C_SNAP_E : rsch_pkg::C_SNAP_S;
                phase_next = P_DIST;
                state_next = S_DIFF;
            end
            S_ROOT:
            begin
                op = rsch_pkg::C_ROOT_START;
                state_next = S_RRUN;
            end
            S_RRUN:
            begin
                op = rsch_pkg::C_ROOT_RUN;
                if (st.root_done)
                begin
                    state_next = (phase_reg == P_D0) ? S_THR : S_LEN;
                end
            end
            S_THR:
            begin
                op = rsch_pkg::C_THR;
                state_next = S_T2;
            end
            S_T2:
            begin
                op = rsch_pkg::C_THR2_START;
                state_next = S_T2RUN;
            end
            S_T2RUN:
            begin
                op = rsch_pkg::C_MUL_RUN;
                if (st.mul_done)
                begin
                    phase_next = P_E;
                    state_next = S_DIFF;
                end
            end
            S_LEN:
            begin
                state_next = st.len_ok ? S_FIN_HIT : S_FIN_MISS;
            end
            S_FIN_HIT:
            begin
                if (!st.out_busy)
                begin
                    op = rsch_pkg::C_FIN_HIT;
                    state_next = S_IDLE;
                end
            end
            S_FIN_MISS:
            begin
                if (!st.out_busy)
                begin
                    op = rsch_pkg::C_FIN_MISS;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= P_D0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

[sv/rsch_dpath.sv]
// ----------------------------------------------------------------------------
// rsch_dpath
// Datapath: shared multiplier, serial multiplier, divider and square root,
// hit point registers, kept closest hit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsch_dpath #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  rsch_pkg::cmd_t                     op,
    output rsch_pkg::status_t                  st,
    input  wire logic signed [COORD_WIDTH-1:0] ray_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] ray_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] ray_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] ray_end_y,
    input  wire logic [COORD_WIDTH-2:0]        ray_max_length,
    input  wire logic [7:0]                    tolerance,
    input  wire logic [15:0]                   snap_slope,
    input  wire logic                          snap_enable,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] seg_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] seg_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] seg_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] seg_end_y,
    input  wire logic                          first_segment,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               segment_hit,
    output logic                               closest_valid,
    output logic signed [COORD_WIDTH-1:0]      closest_x,
    output logic signed [COORD_WIDTH-1:0]      closest_y,
    output logic [COORD_WIDTH-2:0]             closest_distance
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int PW  = 2 * DW;
    localparam int NW  = PW + 1;
    localparam int AW  = 3 * W + 48;
    localparam int MB  = W + 10;
    localparam int HW  = W + 43;
    localparam int SQW = 2 * W + 2;
    localparam int RW  = W + 1;
    localparam int EW  = 8 + FRAC_BITS;
    localparam int QB  = rsch_pkg::DIV_QBITS;
    localparam int CW  = rsch_pkg::DIV_CNTW;
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-2:0] LMAX = {(W-1){1'b1}};

    function automatic logic in_box(input logic signed [HW-1:0] h,
                                    input logic signed [W-1:0] a,
                                    input logic signed [W-1:0] b,
                                    input logic [7:0] t);
        logic signed [HW-1:0] lo;
        logic signed [HW-1:0] hi;
        logic signed [HW-1:0] ts;
        ts = $signed(HW'(t));
        lo = (a < b) ? HW'(a) : HW'(b);
        hi = (a < b) ? HW'(b) : HW'(a);
        return (h >= lo - ts) && (h <= hi + ts);
    endfunction

    logic signed [W-1:0]  ssx_reg, ssy_reg, sex_reg, sey_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, ex_reg, ey_reg, wx_reg, wy_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [NW-1:0] tmp_reg, den_reg, num_reg;
    logic [AW-1:0]        mp_acc_reg, mp_a_reg;
    logic [MB-1:0]        mp_b_reg;
    logic                 ofs_neg_reg;
    logic [AW-1:0]        dv_r_reg, dv_d_reg;
    logic [QB-1:0]        dv_q_reg;
    logic [CW-1:0]        dv_cnt_reg;
    logic signed [HW-1:0] hx_reg, hy_reg;
    logic signed [W-1:0]  cx_reg, cy_reg;
    logic signed [DW-1:0] ux_reg, uy_reg;
    logic [SQW-1:0]       sq_reg, rt_v_reg, rt_res_reg, rt_bit_reg;
    logic [MB-1:0]        thr_reg;
    logic                 kept_valid_reg;
    logic signed [W-1:0]  kept_x_reg, kept_y_reg;
    logic [W-2:0]         kept_dist_reg;
    logic                 out_valid_reg, seg_hit_reg, cl_valid_reg;
    logic signed [W-1:0]  cl_x_reg, cl_y_reg;
    logic [W-2:0]         cl_dist_reg;

    logic signed [DW-1:0] ma, mb;
    logic signed [PW-1:0] mul_p;
    logic signed [NW-1:0] diff_nw, sum_nw;
    logic [NW-1:0]        den_mag, num_mag;
    logic [DW-1:0]        dx_mag, dy_mag;
    logic [EW-1:0]        eps_w;
    logic [AW-1:0]        dv_n, dv_dd;
    logic                 dv_sat, dv_ge;
    logic [QB-1:0]        qc;
    logic signed [HW-1:0] qs, ofs;
    logic [SQW-1:0]       rt_t;
    logic                 rt_ge;
    logic [RW-1:0]        root;
    logic [RW+15:0]       thr_full;
    logic [W-2:0]         ds;
    logic                 load_fire, upd;

    assign load_fire = (op == rsch_pkg::C_LOAD) && in_valid;

    always_comb
    begin
        case (op)
            rsch_pkg::C_DEN_A:
            begin
                ma = dx_reg;
                mb = ey_reg;
            end
            rsch_pkg::C_DEN_B:
            begin
                ma = dy_reg;
                mb = ex_reg;
            end
            rsch_pkg::C_DEN_C:
            begin
                ma = wx_reg;
                mb = ey_reg;
            end
            rsch_pkg::C_NUM_B:
            begin
                ma = wy_reg;
                mb = ex_reg;
            end
            rsch_pkg::C_SQ_A:
            begin
                ma = ux_reg;
                mb = ux_reg;
            end
            rsch_pkg::C_SQ_B:
            begin
                ma = uy_reg;
                mb = uy_reg;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign mul_p   = PW'(ma) * PW'(mb);
    assign diff_nw = tmp_reg - NW'(prod_reg);
    assign sum_nw  = tmp_reg + NW'(prod_reg);

    assign den_mag = den_reg[NW-1] ? $unsigned(-den_reg) : $unsigned(den_reg);
    assign num_mag = num_reg[NW-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
    assign dx_mag  = dx_reg[DW-1] ? $unsigned(-dx_reg) : $unsigned(dx_reg);
    assign dy_mag  = dy_reg[DW-1] ? $unsigned(-dy_reg) : $unsigned(dy_reg);
    assign eps_w   = EW'(tolerance) << FRAC_BITS;

    // Rounded quotient: (2*|dir*num| + |den|) / (2*|den|).
    assign dv_n   = (mp_acc_reg << 1) + AW'(den_mag);
    assign dv_dd  = AW'(den_mag) << 1;
    assign dv_sat = dv_n >= (dv_dd << QB);
    assign dv_ge  = dv_r_reg >= dv_d_reg;

    assign qc  = (dv_q_reg > rsch_pkg::Q_CLAMP) ? rsch_pkg::Q_CLAMP : dv_q_reg;
    assign qs  = $signed(HW'(qc));
    assign ofs = ofs_neg_reg ? -qs : qs;

    assign rt_t  = rt_res_reg + rt_bit_reg;
    assign rt_ge = rt_v_reg >= rt_t;
    assign root  = rt_res_reg[RW-1:0];

    assign thr_full = (RW+16)'(root) * (RW+16)'(snap_slope);
    assign ds = (root > RW'(LMAX)) ? LMAX : root[W-2:0];
    assign upd = (op == rsch_pkg::C_FIN_HIT) && (!kept_valid_reg || ds < kept_dist_reg);

    always_comb
    begin
        st.parallel  = (den_reg == '0) || (den_mag < NW'(eps_w));
        st.box_ok    = in_box(hx_reg, ssx_reg, sex_reg, tolerance)
                    && in_box(hy_reg, ssy_reg, sey_reg, tolerance)
                    && in_box(hx_reg, ray_start_x, ray_end_x, tolerance)
                    && in_box(hy_reg, ray_start_y, ray_end_y, tolerance);
        st.mul_done  = (mp_b_reg == '0);
        st.div_done  = (dv_cnt_reg == '0);
        st.root_done = (rt_bit_reg == '0);
        st.snap_lt   = AW'(sq_reg) < mp_acc_reg;
        st.len_ok    = (W+1)'(root) <= ((W+1)'(ray_max_length) + (W+1)'(tolerance));
        st.out_busy  = out_valid_reg && out_stall;
        st.snap_en   = snap_enable;
    end

    // Control state and the kept hit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_valid_reg <= 1'b0;
            kept_x_reg     <= '0;
            kept_y_reg     <= '0;
            kept_dist_reg  <= '0;
            out_valid_reg  <= 1'b0;
            mp_b_reg       <= '0;
            dv_cnt_reg     <= '0;
            rt_bit_reg     <= '0;
        end
        else
        begin
            if (load_fire && first_segment)
            begin
                kept_valid_reg <= 1'b0;
                kept_x_reg     <= '0;
                kept_y_reg     <= '0;
                kept_dist_reg  <= '0;
            end
            else if (upd)
            begin
                kept_valid_reg <= 1'b1;
                kept_x_reg     <= cx_reg;
                kept_y_reg     <= cy_reg;
                kept_dist_reg  <= ds;
            end

            if (op == rsch_pkg::C_FIN_HIT || op == rsch_pkg::C_FIN_MISS)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (op)
                rsch_pkg::C_OFS_MUL_X:
                begin
                    mp_b_reg <= MB'(dx_mag);
                end
                rsch_pkg::C_OFS_MUL_Y:
                begin
                    mp_b_reg <= MB'(dy_mag);
                end
                rsch_pkg::C_THR2_START:
                begin
                    mp_b_reg <= thr_reg;
                end
                rsch_pkg::C_MUL_RUN:
                begin
                    mp_b_reg <= mp_b_reg >> 1;
                end
                rsch_pkg::C_DIV_START:
                begin
                    dv_cnt_reg <= dv_sat ? '0 : CW'(QB);
                end
                rsch_pkg::C_DIV_RUN:
                begin
                    if (dv_cnt_reg != '0)
                    begin
                        dv_cnt_reg <= dv_cnt_reg - CW'(1);
                    end
                end
                rsch_pkg::C_ROOT_START:
                begin
                    rt_bit_reg <= SQW'(1) << (SQW - 2);
                end
                rsch_pkg::C_ROOT_RUN:
                begin
                    rt_bit_reg <= rt_bit_reg >> 2;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (op)
            rsch_pkg::C_LOAD:
            begin
                if (in_valid)
                begin
                    ssx_reg <= seg_start_x;
                    ssy_reg <= seg_start_y;
                    sex_reg <= seg_end_x;
                    sey_reg <= seg_end_y;
                    dx_reg  <= DW'(ray_end_x) - DW'(ray_start_x);
                    dy_reg  <= DW'(ray_end_y) - DW'(ray_start_y);
                    ex_reg  <= DW'(seg_end_x) - DW'(seg_start_x);
                    ey_reg  <= DW'(seg_end_y) - DW'(seg_start_y);
                    wx_reg  <= DW'(seg_start_x) - DW'(ray_start_x);
                    wy_reg  <= DW'(seg_start_y) - DW'(ray_start_y);
                end
            end
            rsch_pkg::C_DEN_B, rsch_pkg::C_NUM_B, rsch_pkg::C_SQ_B:
            begin
                tmp_reg <= NW'(prod_reg);
            end
            rsch_pkg::C_DEN_C:
            begin
                den_reg <= diff_nw;
            end
            rsch_pkg::C_NUM_C:
            begin
                num_reg <= diff_nw;
            end
            rsch_pkg::C_OFS_MUL_X:
            begin
                mp_acc_reg  <= '0;
                mp_a_reg    <= AW'(num_mag);
                ofs_neg_reg <= num_reg[NW-1] ^ den_reg[NW-1] ^ dx_reg[DW-1];
            end
            rsch_pkg::C_OFS_MUL_Y:
            begin
                mp_acc_reg  <= '0;
                mp_a_reg    <= AW'(num_mag);
                ofs_neg_reg <= num_reg[NW-1] ^ den_reg[NW-1] ^ dy_reg[DW-1];
            end
            rsch_pkg::C_THR2_START:
            begin
                mp_acc_reg <= '0;
                mp_a_reg   <= AW'(thr_reg);
            end
            rsch_pkg::C_MUL_RUN:
            begin
                if (mp_b_reg != '0)
                begin
                    if (mp_b_reg[0])
                    begin
                        mp_acc_reg <= mp_acc_reg + mp_a_reg;
                    end
                    mp_a_reg <= mp_a_reg << 1;
                end
            end
            rsch_pkg::C_DIV_START:
            begin
                dv_r_reg <= dv_n;
                dv_d_reg <= dv_dd << (QB - 1);
                dv_q_reg <= dv_sat ? rsch_pkg::Q_CLAMP : '0;
            end
            rsch_pkg::C_DIV_RUN:
            begin
                if (dv_cnt_reg != '0)
                begin
                    if (dv_ge)
                    begin
                        dv_r_reg <= dv_r_reg - dv_d_reg;
                    end
                    dv_q_reg <= {dv_q_reg[QB-2:0], dv_ge};
                    dv_d_reg <= dv_d_reg >> 1;
                end
            end
            rsch_pkg::C_OFS_SET_X:
            begin
                hx_reg <= HW'(ray_start_x) + ofs;
            end
            rsch_pkg::C_OFS_SET_Y:
            begin
                hy_reg <= HW'(ray_start_y) + ofs;
            end
            rsch_pkg::C_CLAMP:
            begin
                cx_reg <= (hx_reg > HW'(CMAX)) ? CMAX :
                          (hx_reg < HW'(CMIN)) ? CMIN : $signed(hx_reg[W-1:0]);
                cy_reg <= (hy_reg > HW'(CMAX)) ? CMAX :
                          (hy_reg < HW'(CMIN)) ? CMIN : $signed(hy_reg[W-1:0]);
            end
            rsch_pkg::C_DIFF_R:
            begin
                ux_reg <= DW'(cx_reg) - DW'(ray_start_x);
                uy_reg <= DW'(cy_reg) - DW'(ray_start_y);
            end
            rsch_pkg::C_DIFF_E:
            begin
                ux_reg <= DW'(cx_reg) - DW'(sex_reg);
                uy_reg <= DW'(cy_reg) - DW'(sey_reg);
            end
            rsch_pkg::C_DIFF_S:
            begin
                ux_reg <= DW'(cx_reg) - DW'(ssx_reg);
                uy_reg <= DW'(cy_reg) - DW'(ssy_reg);
            end
            rsch_pkg::C_SQ_C:
            begin
                sq_reg <= sum_nw[SQW-1:0];
            end
            rsch_pkg::C_SNAP_E:
            begin
                cx_reg <= sex_reg;
                cy_reg <= sey_reg;
            end
            rsch_pkg::C_SNAP_S:
            begin
                cx_reg <= ssx_reg;
                cy_reg <= ssy_reg;
            end
            rsch_pkg::C_ROOT_START:
            begin
                rt_v_reg   <= sq_reg;
                rt_res_reg <= '0;
            end
            rsch_pkg::C_ROOT_RUN:
            begin
                if (rt_bit_reg != '0)
                begin
                    if (rt_ge)
                    begin
                        rt_v_reg   <= rt_v_reg - rt_t;
                        rt_res_reg <= (rt_res_reg >> 1) + rt_bit_reg;
                    end
                    else
                    begin
                        rt_res_reg <= rt_res_reg >> 1;
                    end
                end
            end
            rsch_pkg::C_THR:
            begin
                thr_reg <= MB'(thr_full >> rsch_pkg::SLOPE_FRAC);
            end
            rsch_pkg::C_FIN_HIT, rsch_pkg::C_FIN_MISS:
            begin
                seg_hit_reg  <= (op == rsch_pkg::C_FIN_HIT);
                cl_valid_reg <= upd ? 1'b1 : kept_valid_reg;
                cl_x_reg     <= upd ? cx_reg : kept_x_reg;
                cl_y_reg     <= upd ? cy_reg : kept_y_reg;
                cl_dist_reg  <= upd ? ds : kept_dist_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid        = out_valid_reg;
    assign segment_hit      = seg_hit_reg;
    assign closest_valid    = cl_valid_reg;
    assign closest_x        = cl_x_reg;
    assign closest_y        = cl_y_reg;
    assign closest_distance = cl_dist_reg;

endmodule

`default_nettype wire

[sv/ray_segment_closest_hit.sv]
// ----------------------------------------------------------------------------
// ray_segment_closest_hit
// Tests 2D segments against a configured ray and keeps the closest hit.
// ----------------------------------------------------------------------------
// One segment is worked on at a time; a new word is taken only once the
// previous one has been handed to the result register. A segment rejected as
// parallel goes straight to its result. Otherwise each of the two hit point
// offsets goes through the serial shift-add multiplier, one bit per cycle,
// and then the 41-step divider. A box miss then ends, while a hit goes on to
// the bit-pair square root of its distance. Snapping adds a square root of
// the distance from the ray start to the hit, a serial multiply that squares
// the snap threshold and up to two end point comparisons. A result waits in
// its output register while the next segment is accepted.
// Configuration writes are always taken and must happen while the block is
// idle.
`default_nettype none

module ray_segment_closest_hit #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [((COORD_WIDTH > 16) ? COORD_WIDTH : 16)-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] seg_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] seg_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] seg_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] seg_end_y,
    input  wire logic                          first_segment,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               segment_hit,
    output logic                               closest_valid,
    output logic signed [COORD_WIDTH-1:0]      closest_x,
    output logic signed [COORD_WIDTH-1:0]      closest_y,
    output logic [COORD_WIDTH-2:0]             closest_distance
);

    logic signed [COORD_WIDTH-1:0] ray_start_x_reg, ray_start_y_reg;
    logic signed [COORD_WIDTH-1:0] ray_end_x_reg, ray_end_y_reg;
    logic [COORD_WIDTH-2:0]        ray_max_length_reg;
    logic [7:0]                    tolerance_reg;
    logic [15:0]                   snap_slope_reg;
    logic                          snap_enable_reg;

    rsch_pkg::cmd_t    op;
    rsch_pkg::status_t st;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_start_x_reg    <= '0;
            ray_start_y_reg    <= '0;
            ray_end_x_reg      <= '0;
            ray_end_y_reg      <= '0;
            ray_max_length_reg <= '0;
            tolerance_reg      <= 8'd1;
            snap_slope_reg     <= '0;
            snap_enable_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (rsch_pkg::cfg_idx_t'(cfg_index))
                rsch_pkg::CFG_RAY_START_X:    ray_start_x_reg <= $signed(cfg_data[COORD_WIDTH-1:0]);
                rsch_pkg::CFG_RAY_START_Y:    ray_start_y_reg <= $signed(cfg_data[COORD_WIDTH-1:0]);
                rsch_pkg::CFG_RAY_END_X:      ray_end_x_reg <= $signed(cfg_data[COORD_WIDTH-1:0]);
                rsch_pkg::CFG_RAY_END_Y:      ray_end_y_reg <= $signed(cfg_data[COORD_WIDTH-1:0]);
                rsch_pkg::CFG_RAY_MAX_LENGTH: ray_max_length_reg <= cfg_data[COORD_WIDTH-2:0];
                rsch_pkg::CFG_TOLERANCE:      tolerance_reg <= cfg_data[7:0];
                rsch_pkg::CFG_SNAP_SLOPE:     snap_slope_reg <= cfg_data[15:0];
                rsch_pkg::CFG_SNAP_ENABLE:    snap_enable_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    rsch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .op       (op)
    );

    rsch_dpath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .st               (st),
        .ray_start_x      (ray_start_x_reg),
        .ray_start_y      (ray_start_y_reg),
        .ray_end_x        (ray_end_x_reg),
        .ray_end_y        (ray_end_y_reg),
        .ray_max_length   (ray_max_length_reg),
        .tolerance        (tolerance_reg),
        .snap_slope       (snap_slope_reg),
        .snap_enable      (snap_enable_reg),
        .in_valid         (in_valid),
        .seg_start_x      (seg_start_x),
        .seg_start_y      (seg_start_y),
        .seg_end_x        (seg_end_x),
        .seg_end_y        (seg_end_y),
        .first_segment    (first_segment),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .segment_hit      (segment_hit),
        .closest_valid    (closest_valid),
        .closest_x        (closest_x),
        .closest_y        (closest_y),
        .closest_distance (closest_distance)
    );

    // The block works on one segment at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("segment accepted while another is in progress");

    // A hit on this segment always leaves a kept hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && segment_hit) |-> closest_valid)
        else $error("hit reported without a kept hit");

    // With no kept hit the reported point and distance are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !closest_valid) |->
            (closest_distance == '0 && closest_x == '0 && closest_y == '0))
        else $error("stale closest hit reported");

endmodule

`default_nettype wire

[tb/rsch_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsch_checker
// Watches the configuration, segment and result channels of the closest hit
// block, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module rsch_checker #(
    parameter int CW = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [CW-1:0]        cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic signed [CW-1:0] seg_start_x,
    input  wire logic signed [CW-1:0] seg_start_y,
    input  wire logic signed [CW-1:0] seg_end_x,
    input  wire logic signed [CW-1:0] seg_end_y,
    input  wire logic                 first_segment,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic                 segment_hit,
    input  wire logic                 closest_valid,
    input  wire logic signed [CW-1:0] closest_x,
    input  wire logic signed [CW-1:0] closest_y,
    input  wire logic [CW-2:0]        closest_distance,
    output int                        fail_count,
    output int                        pending,
    output int                        hits_seen,
    output int                        results_seen
);

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic                 hit;
        logic                 cvalid;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [CW-2:0]        cdist;
    } closest_word_t;

    localparam longint CMAX = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint CMIN = -(longint'(1) <<< (CW - 1));
    localparam longint QSAT = longint'(1) <<< 40;

    // Copy of the configuration registers and the kept hit.
    logic signed [CW-1:0] ray_sx, ray_sy, ray_ex, ray_ey;
    logic [CW-2:0]        max_len;
    logic [7:0]           tol;
    logic [15:0]          slope;
    logic                 snap_on;
    logic                 kept_valid;
    longint               kept_x, kept_y;
    longint               kept_dist;

    closest_word_t closest_q[$];

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch @%0t: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic longint unsigned isqrt(input logic [127:0] v);
        logic [127:0] res;
        logic [127:0] t;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            t = res | (128'd1 << b);
            if (t * t <= v)
                res = t;
        end
        return res[63:0];
    endfunction

    function automatic logic [127:0] sqsum(input longint ax, input longint ay);
        wide_t sx, sy;
        sx = wide_t'(ax) * wide_t'(ax);
        sy = wide_t'(ay) * wide_t'(ay);
        return sx + sy;
    endfunction

    // dir * num / den rounded half away from zero, magnitude saturated.
    function automatic longint hit_offset(input longint dir, input wide_t num,
                                          input wide_t den);
        logic [127:0] an, ad, md, q;
        logic         neg;
        an  = num < 0 ? -num : num;
        ad  = den < 0 ? -den : den;
        md  = dir < 0 ? -dir : dir;
        neg = (num < 0) ^ (den < 0) ^ (dir < 0);
        q   = ((an * md) * 2 + ad) / (ad * 2);
        if (q > QSAT)
            q = QSAT;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic in_box(input longint h, input longint a, input longint b,
                                    input longint t);
        longint lo, hi;
        lo = a < b ? a : b;
        hi = a < b ? b : a;
        return h >= lo - t && h <= hi + t;
    endfunction

    function automatic longint clamp_coord(input longint v);
        return v < CMIN ? CMIN : (v > CMAX ? CMAX : v);
    endfunction

    task automatic predict_closest_hit(input longint ssx, input longint ssy,
                                       input longint sex, input longint sey,
                                       input logic first, output closest_word_t w);
        longint rsx, rsy, rex, rey, dx, dy, ex, ey, wx, wy, hx, hy, t;
        wide_t den, num, eps;
        longint unsigned d0, thr, hit_dist, ds;
        logic [127:0] thr2;
        logic hit;
        rsx = ray_sx; rsy = ray_sy; rex = ray_ex; rey = ray_ey;
        t   = tol;
        dx  = rex - rsx; dy = rey - rsy;
        ex  = sex - ssx; ey = sey - ssy;
        wx  = ssx - rsx; wy = ssy - rsy;
        den = wide_t'(dx) * wide_t'(ey) - wide_t'(dy) * wide_t'(ex);
        eps = wide_t'(t) <<< 8;
        hit = 1'b0;
        if (first) begin
            kept_valid = 1'b0; kept_x = 0; kept_y = 0; kept_dist = 0;
        end
        if (den != 0 && (den < 0 ? -den : den) >= eps) begin
            num = wide_t'(wx) * wide_t'(ey) - wide_t'(wy) * wide_t'(ex);
            hx  = rsx + hit_offset(dx, num, den);
            hy  = rsy + hit_offset(dy, num, den);
            if (in_box(hx, ssx, sex, t) && in_box(hy, ssy, sey, t) &&
                in_box(hx, rsx, rex, t) && in_box(hy, rsy, rey, t)) begin
                hx = clamp_coord(hx);
                hy = clamp_coord(hy);
                if (snap_on) begin
                    d0   = isqrt(sqsum(hx - rsx, hy - rsy));
                    thr  = (d0 * slope) >> rsch_pkg::SLOPE_FRAC;
                    thr2 = 128'(thr) * 128'(thr);
                    if (sqsum(hx - sex, hy - sey) < thr2) begin
                        hx = sex; hy = sey;
                    end else if (sqsum(hx - ssx, hy - ssy) < thr2) begin
                        hx = ssx; hy = ssy;
                    end
                end
                hit_dist = isqrt(sqsum(hx - rsx, hy - rsy));
                if (hit_dist <= longint'(max_len) + t) begin
                    ds  = hit_dist > CMAX ? CMAX : hit_dist;
                    hit = 1'b1;
                    if (!kept_valid || ds < kept_dist) begin
                        kept_valid = 1'b1; kept_x = hx; kept_y = hy; kept_dist = ds;
                    end
                end
            end
        end
        w.hit    = hit;
        w.cvalid = kept_valid;
        w.cx     = kept_x[CW-1:0];
        w.cy     = kept_y[CW-1:0];
        w.cdist  = kept_dist[CW-2:0];
    endtask

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        hits_seen    = 0;
        results_seen = 0;
    end

    // Channels are sampled at the falling edge: a word seen there with valid
    // high and stall low is the one taken at the next rising edge.
    always @(negedge clk)
    begin
        closest_word_t w;
        if (!rst_n) begin
            ray_sx = '0; ray_sy = '0; ray_ex = '0; ray_ey = '0;
            max_len = '0; tol = 8'd1; slope = '0; snap_on = 1'b0;
            kept_valid = 1'b0; kept_x = 0; kept_y = 0; kept_dist = 0;
            closest_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (rsch_pkg::cfg_idx_t'(cfg_index))
                    rsch_pkg::CFG_RAY_START_X:    ray_sx = cfg_data;
                    rsch_pkg::CFG_RAY_START_Y:    ray_sy = cfg_data;
                    rsch_pkg::CFG_RAY_END_X:      ray_ex = cfg_data;
                    rsch_pkg::CFG_RAY_END_Y:      ray_ey = cfg_data;
                    rsch_pkg::CFG_RAY_MAX_LENGTH: max_len = cfg_data[CW-2:0];
                    rsch_pkg::CFG_TOLERANCE:      tol = cfg_data[7:0];
                    rsch_pkg::CFG_SNAP_SLOPE:     slope = cfg_data[15:0];
                    rsch_pkg::CFG_SNAP_ENABLE:    snap_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                results_seen++;
                if (closest_q.size() == 0) begin
                    report("result words outstanding", 0, 1);
                end else begin
                    w = closest_q.pop_front();
                    if (segment_hit)
                        hits_seen++;
                    if (segment_hit !== w.hit)
                        report("segment_hit", segment_hit, w.hit);
                    if (closest_valid !== w.cvalid)
                        report("closest_valid", closest_valid, w.cvalid);
                    if (closest_x !== w.cx)
                        report("closest_x", closest_x, w.cx);
                    if (closest_y !== w.cy)
                        report("closest_y", closest_y, w.cy);
                    if (closest_distance !== w.cdist)
                        report("closest_distance", closest_distance, w.cdist);
                end
            end
            if (in_valid && !in_stall) begin
                predict_closest_hit(seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                                    first_segment, w);
                closest_q.push_back(w);
            end
        end
        pending = closest_q.size();
    end

endmodule

`default_nettype wire

[tb/ray_segment_closest_hit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_segment_closest_hit_tb
// Drives rays and segment streams into the closest hit block, with random
// input gaps and output stalls, and lets the checker judge every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_segment_closest_hit_tb;

    localparam int CW = 24;
    localparam longint CMAX = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint CMIN = -(longint'(1) <<< (CW - 1));

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [CW-1:0] seg_start_x = '0;
    logic signed [CW-1:0] seg_start_y = '0;
    logic signed [CW-1:0] seg_end_x = '0;
    logic signed [CW-1:0] seg_end_y = '0;
    logic first_segment = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic segment_hit;
    logic closest_valid;
    logic signed [CW-1:0] closest_x;
    logic signed [CW-1:0] closest_y;
    logic [CW-2:0] closest_distance;

    int fail_count, pending, hits_seen, results_seen;
    logic idle_on = 1'b0;
    int stall_left = 0;
    int sent = 0;

    // Current ray, kept here to aim segments at it.
    longint ray_sx, ray_sy, ray_ex, ray_ey;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ray_segment_closest_hit #(.COORD_WIDTH(CW), .FRAC_BITS(8)) dut (.*);

    rsch_checker #(.CW(CW)) checker_i (.*);

    always @(posedge clk)
    begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic longint sat(input longint v);
        return v < CMIN ? CMIN : (v > CMAX ? CMAX : v);
    endfunction

    function automatic longint rand_coord(input int bits);
        if (bits >= CW - 1)
            return longint'($signed(CW'($urandom)));
        return longint'($urandom_range(0, (1 << (bits + 1)) - 1)) - (longint'(1) << bits);
    endfunction

    task automatic cfg_write(input rsch_pkg::cfg_idx_t idx, input longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CW-1:0];
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_ray(input longint sx, input longint sy, input longint ex,
                           input longint ey, input longint maxl, input int tolr,
                           input int slp, input int en);
        ray_sx = sx; ray_sy = sy; ray_ex = ex; ray_ey = ey;
        cfg_write(rsch_pkg::CFG_RAY_START_X, sx);
        cfg_write(rsch_pkg::CFG_RAY_START_Y, sy);
        cfg_write(rsch_pkg::CFG_RAY_END_X, ex);
        cfg_write(rsch_pkg::CFG_RAY_END_Y, ey);
        cfg_write(rsch_pkg::CFG_RAY_MAX_LENGTH, maxl);
        cfg_write(rsch_pkg::CFG_TOLERANCE, tolr);
        cfg_write(rsch_pkg::CFG_SNAP_SLOPE, slp);
        cfg_write(rsch_pkg::CFG_SNAP_ENABLE, en);
    endtask

    task automatic send_seg(input longint sx, input longint sy, input longint ex,
                            input longint ey, input logic first);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        seg_start_x   <= sx[CW-1:0];
        seg_start_y   <= sy[CW-1:0];
        seg_end_x     <= ex[CW-1:0];
        seg_end_y     <= ey[CW-1:0];
        first_segment <= first;
        in_valid      <= 1'b1;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Mostly segments that cross the ray somewhere near it, some parallel to
    // it, and some entirely random words.
    task automatic random_seg();
        longint px, py, vx, vy, a, b, k, dx, dy, sx, sy;
        int kind, vb;
        logic first;
        first = ($urandom_range(0, 7) == 0);
        kind  = $urandom_range(0, 19);
        dx = ray_ex - ray_sx;
        dy = ray_ey - ray_sy;
        if (kind < 14) begin
            k  = $urandom_range(0, 300);
            px = ray_sx + dx * k / 256;
            py = ray_sy + dy * k / 256;
            vb = $urandom_range(4, 20);
            vx = rand_coord(vb);
            vy = rand_coord(vb);
            // Short tails put the hit close to an end point.
            a  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 256);
            b  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 256);
            send_seg(sat(px - vx * a / 256), sat(py - vy * a / 256),
                     sat(px + vx * b / 256), sat(py + vy * b / 256), first);
        end else if (kind < 17) begin
            sx = rand_coord($urandom_range(8, 23));
            sy = rand_coord($urandom_range(8, 23));
            k  = $urandom_range(0, 512);
            send_seg(sx, sy, sat(sx + dx * k / 256 + $urandom_range(0, 2)),
                     sat(sy + dy * k / 256), first);
        end else begin
            send_seg(rand_coord(23), rand_coord(23), rand_coord(23), rand_coord(23), first);
        end
    endtask

    initial
    begin
        int bits;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ray from the origin along +x, 100.0 long.
        set_ray(0, 0, 25600, 0, CMAX, 1, 0, 0);
        send_seg(12800, -2560, 12800, 2560, 1'b1);       // plain crossing at x=50
        send_seg(0, 256, 25600, 256, 1'b0);              // parallel
        send_seg(1280, 0, 2560, 0, 1'b0);                // collinear, zero det
        send_seg(1280, 5, 1280, 5, 1'b0);                // degenerate segment
        send_seg(6400, -256, 6400, 256, 1'b0);           // closer hit replaces
        send_seg(19200, -256, 19200, 256, 1'b0);         // farther hit kept out
        send_seg(-6400, -256, -6400, 256, 1'b0);         // behind the origin
        send_seg(30000, -256, 30000, 256, 1'b0);         // past the ray end
        send_seg(25601, -256, 25601, 256, 1'b0);         // inside the padding
        send_seg(100, 1, 100, 300, 1'b0);                // touches within tolerance
        send_seg(CMIN, CMIN, CMAX, CMAX, 1'b0);          // extreme diagonal
        send_seg(CMAX, CMIN, CMIN, CMAX, 1'b0);
        send_seg(CMIN, CMAX, CMIN, CMIN, 1'b0);
        send_seg(-1, 0, 0, -1, 1'b0);
        send_seg(3000, 3000, 3000, 3001, 1'b1);          // miss right after clear
        send_seg(3000, -1, 3001, 1, 1'b0);
        drain();

        // Snapping, zero tolerance, short ray limit.
        set_ray(-2560, -2560, 2560, 2560, 1500, 0, 16'hFFFF, 1);
        send_seg(0, -256, 0, 256, 1'b1);
        send_seg(-256, 256, 256, -256, 1'b0);
        send_seg(1000, 900, 900, 1000, 1'b0);
        send_seg(2000, -100, 2000, 4000, 1'b0);
        drain();

        for (int ph = 1; ph <= 6; ph++) begin
            idle_on = (ph < 6);
            case (ph)
                1: set_ray(0, 0, rand_coord(14), rand_coord(14), CMAX, 0, 16'hFFFF, 1);
                2: set_ray(rand_coord(12), rand_coord(12), rand_coord(16), rand_coord(16),
                           CMAX, 255, 0, 0);
                3: set_ray(CMIN, CMIN, CMAX, CMAX, 0, $urandom_range(0, 255), 26, 1);
                default: begin
                    bits = $urandom_range(10, 23);
                    set_ray(rand_coord(bits), rand_coord(bits), rand_coord(bits),
                            rand_coord(bits), $urandom_range(0, CMAX),
                            $urandom_range(0, 255), $urandom_range(0, 16'hFFFF),
                            $urandom_range(0, 1));
                end
            endcase
            repeat (145) random_seg();
            drain();
        end

        $display("Sent %0d segments over eight ray settings; %0d results, %0d hits.",
                 sent, results_seen, hits_seen);
        if (fail_count == 0)
            $display("PASS ray_segment_closest_hit");
        else
            $display("FAIL ray_segment_closest_hit");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("FAIL ray_segment_closest_hit");
        $finish;
    end

endmodule

`default_nettype wire
